// ===== rtl/core/pba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and constants of the paged block allocator: command and status
// codes, register indexes and the request and response of the shared divider.
// ----------------------------------------------------------------------------
package pba_pkg;

  // Fixed field widths.
  localparam int BS_W     = 13;  // block size register
  localparam int RES_W    = 11;  // reserved blocks register
  localparam int TOK_W    = 16;  // token counts
  localparam int DIVD_W   = 17;  // dividend of the shared divider
  localparam int DIV_CNT_W = 5;  // step counter of the divider
  localparam int BID_W    = 11;  // reported block id
  localparam int OLEN_W   = 7;   // reported list length
  localparam int OFREE_W  = 11;  // reported free count

  // Block id reported beyond the end of a list.
  localparam logic signed [BID_W-1:0] BLOCK_NONE = -11'sd1;

  // Register indexes of the configuration port.
  localparam logic REG_BLOCK_SIZE = 1'b0;
  localparam logic REG_RESERVED   = 1'b1;

  // Reset values of the registers.
  localparam logic [BS_W-1:0]  BS_RESET  = 13'd16;
  localparam logic [RES_W-1:0] RES_RESET = 11'd0;

  typedef enum logic [2:0] {
    CMD_ALLOC = 3'd0,
    CMD_FREE  = 3'd1,
    CMD_APPB  = 3'd2,
    CMD_APPT  = 3'd3,
    CMD_READ  = 3'd4
  } pba_cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFREE  = 3'd1,
    ST_EXISTS  = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_FULL    = 3'd4,
    ST_BADCNT  = 3'd5
  } pba_status_t;

  // Request to the shared divider: start is a one-cycle pulse.
  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [BS_W-1:0]   divisor;
  } pba_div_req_t;

  // Response of the shared divider: done is a one-cycle pulse.
  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quot;
    logic [BS_W-1:0]   rem;
  } pba_div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/pba_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pba_div
// Restoring divider shared by all block count computations. It produces one
// quotient bit per cycle and raises done once the last quotient bit is in.
// ----------------------------------------------------------------------------
module pba_div (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pba_pkg::pba_div_req_t req,
  output pba_pkg::pba_div_rsp_t      rsp
);
  import pba_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIVD_W-1:0]    quo_r;
  logic [BS_W-1:0]      rem_r;
  logic [BS_W-1:0]      dsr_r;
  logic [BS_W:0]        trial;
  logic [BS_W:0]        diff;
  logic                 ge;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    trial = {rem_r, quo_r[DIVD_W-1]};
    ge    = (trial >= {1'b0, dsr_r});
    diff  = trial - {1'b0, dsr_r};
  end

  // Step control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient and remainder datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVD_W-2:0], ge};
      rem_r <= ge ? diff[BS_W-1:0] : trial[BS_W-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

// ===== rtl/core/paged_block_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Flow: each command runs two divider passes, or three for append tokens that
// adds blocks, then a decision, a read and a write state per block moved (up to
// MAX_BLOCKS_PER_SEQ), a finish state and the result state.
// One command at a time: a new command is taken only once the last result is
// offered, and a result held in the output register stalls the next command.
// After reset an init pass loads the free queue and clears the sequence table.
// ----------------------------------------------------------------------------
// paged_block_allocator
// Block pool manager: a free block queue, per-sequence block lists and a
// sequencer that allocates, frees, appends and reads list entries.
// ----------------------------------------------------------------------------
module paged_block_allocator #(
  parameter int POOL_BLOCKS        = 1024,
  parameter int MAX_SEQS           = 256,
  parameter int MAX_BLOCKS_PER_SEQ = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [12:0] cfg_data,
  // Commands.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // seq_id[7:0], token_count[23:8], ctx_tokens[39:24], entry_index[45:40]
  input  wire logic [47:0] in_tdata,
  // cmd[2:0]
  input  wire logic [2:0]  in_tuser,
  // Results.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // status[2:0], block_id[13:3], list_length[20:14], free_count[31:21],
  // alloc_ok[32], append_ok[33], has_seq[34]
  output logic [39:0]      out_tdata
);
  import pba_pkg::*;

  localparam int QAW    = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
  localparam int FW     = $clog2(POOL_BLOCKS + 1);
  localparam int SAW    = (MAX_SEQS > 1) ? $clog2(MAX_SEQS) : 1;
  localparam int LW     = $clog2(MAX_BLOCKS_PER_SEQ + 1);
  localparam int LDEPTH = MAX_SEQS * MAX_BLOCKS_PER_SEQ;
  localparam int LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
  localparam int INIT_N = (POOL_BLOCKS > MAX_SEQS) ? POOL_BLOCKS : MAX_SEQS;
  localparam int IW     = $clog2(INIT_N + 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DIVA, S_DIVB, S_DIVC, S_DECIDE,
    S_POP_RD, S_POP_WR, S_PUSH_RD, S_PUSH_WR, S_FINISH, S_RESULT
  } state_t;

  typedef enum logic [1:0] {ACT_NONE, ACT_POP, ACT_PUSH} act_t;

  // Memories.
  logic [QAW-1:0] fq_mem   [POOL_BLOCKS];
  logic [QAW-1:0] list_mem [LDEPTH];
  logic [LW:0]    seq_mem  [MAX_SEQS];   // {valid, length}
  logic [QAW-1:0] fq_rdata_r;
  logic [QAW-1:0] list_rdata_r;
  logic [LW:0]    seq_rdata_r;

  state_t          state_r;
  logic [IW-1:0]   init_cnt_r;
  logic [BS_W-1:0] bs_r;
  logic [RES_W-1:0] res_r;
  logic [QAW-1:0]  free_head_r;
  logic [FW-1:0]   free_total_r;

  // Command context.
  pba_cmd_t        cmd_r;
  logic [SAW-1:0]  sid_r;
  logic            inr_r;
  logic [TOK_W-1:0] tc_r;
  logic [TOK_W-1:0] ctx_r;
  logic [5:0]      idx_r;
  logic [LAW-1:0]  base_r;
  logic            have_r;
  logic [LW-1:0]   len_r;
  logic [LW-1:0]   mv_cnt_r;
  logic [LW-1:0]   pos_r;
  logic [DIVD_W-1:0] need_a_r;
  logic [DIVD_W-1:0] need_c_r;
  logic            grow_r;
  pba_status_t     status_r;

  pba_div_req_t    div_req_r;
  pba_div_rsp_t    div_rsp;

  logic            out_valid_r;
  logic [39:0]     out_data_r;

  // Derived values.
  logic [BS_W-1:0]  bs_eff;
  logic [BS_W-1:0]  slack;
  logic [SAW-1:0]   seq_raddr;
  logic [LAW-1:0]   list_raddr;
  logic [LAW-1:0]   list_waddr;
  logic [QAW-1:0]   fq_tail;
  logic [31:0]      tail_sum;
  logic             in_xfer;
  logic             can_alloc;
  logic             grow_now;
  logic             div_start;
  logic signed [BID_W-1:0] bid;
  pba_status_t      dec_status;
  act_t             dec_act;
  logic [LW-1:0]    dec_cnt;
  logic             dec_new;

  pba_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Address and arithmetic helpers.
  always_comb begin
    bs_eff     = (bs_r == '0) ? BS_W'(1) : bs_r;
    slack      = (div_rsp.rem == '0) ? '0 : bs_eff - div_rsp.rem;
    grow_now   = (cmd_r == CMD_APPT) && (32'(tc_r) > 32'(slack));
    div_start  = ((state_r == S_IDLE) && in_xfer) ||
                 ((state_r == S_DIVA) && div_rsp.done) ||
                 ((state_r == S_DIVB) && div_rsp.done && grow_now);
    seq_raddr  = (state_r == S_IDLE) ? SAW'(in_tdata[7:0]) : sid_r;
    list_waddr = base_r + LAW'(len_r);
    if (state_r == S_PUSH_RD || state_r == S_PUSH_WR) begin
      list_raddr = base_r + LAW'(pos_r);
    end else begin
      list_raddr = base_r + LAW'(idx_r);
    end
    tail_sum = 32'(free_head_r) + 32'(free_total_r);
    fq_tail  = (tail_sum >= POOL_BLOCKS) ? QAW'(tail_sum - POOL_BLOCKS) : QAW'(tail_sum);
    can_alloc = (tc_r != '0) &&
                (32'(free_total_r) >= 32'(need_a_r) + 32'(res_r));
    if (have_r && (32'(idx_r) < 32'(len_r))) begin
      bid = BID_W'(list_rdata_r);
    end else begin
      bid = BLOCK_NONE;
    end
  end

  // Command decision once the block counts are known.
  always_comb begin
    dec_status = ST_OK;
    dec_act    = ACT_NONE;
    dec_cnt    = '0;
    dec_new    = 1'b0;
    if (!inr_r && (cmd_r <= CMD_READ)) begin
      dec_status = ST_UNKNOWN;
    end else begin
      unique case (cmd_r)
        CMD_ALLOC: begin
          priority if (tc_r == '0) dec_status = ST_BADCNT;
          else if (have_r) dec_status = ST_EXISTS;
          else if (32'(need_a_r) > MAX_BLOCKS_PER_SEQ) dec_status = ST_FULL;
          else if (32'(free_total_r) < 32'(need_a_r) + 32'(res_r)) dec_status = ST_NOFREE;
          else begin
            dec_act = ACT_POP;
            dec_cnt = LW'(need_a_r);
            dec_new = 1'b1;
          end
        end
        CMD_FREE: begin
          if (!have_r) dec_status = ST_UNKNOWN;
          else if (len_r != '0) begin
            dec_act = ACT_PUSH;
            dec_cnt = len_r;
          end
        end
        CMD_APPB: begin
          priority if (free_total_r == '0) dec_status = ST_NOFREE;
          else if (!have_r) dec_status = ST_UNKNOWN;
          else if (32'(len_r) >= MAX_BLOCKS_PER_SEQ) dec_status = ST_FULL;
          else begin
            dec_act = ACT_POP;
            dec_cnt = LW'(1);
          end
        end
        CMD_APPT: begin
          priority if (tc_r == '0) dec_status = ST_BADCNT;
          else if (!have_r) dec_status = ST_UNKNOWN;
          else if (grow_r) begin
            priority if (32'(free_total_r) <= 32'(need_c_r)) dec_status = ST_NOFREE;
            else if (32'(len_r) + 32'(need_c_r) > MAX_BLOCKS_PER_SEQ) dec_status = ST_FULL;
            else begin
              dec_act = ACT_POP;
              dec_cnt = LW'(need_c_r);
            end
          end
        end
        CMD_READ: begin
          if (!have_r) dec_status = ST_UNKNOWN;
        end
        default: dec_status = ST_OK;
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r  <= BS_RESET;
      res_r <= RES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BLOCK_SIZE: bs_r  <= cfg_data;
        REG_RESERVED:   res_r <= cfg_data[RES_W-1:0];
        default:        bs_r  <= bs_r;
      endcase
    end
  end

  // Sequencer with its registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_INIT;
      init_cnt_r      <= '0;
      free_head_r     <= '0;
      free_total_r    <= FW'(POOL_BLOCKS);
      out_valid_r     <= 1'b0;
      div_req_r.start <= 1'b0;
    end else begin
      div_req_r.start <= div_start;
      // The result register fills in S_RESULT and empties on a result transfer.
      if (state_r == S_RESULT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_INIT: begin
          init_cnt_r <= init_cnt_r + 1'b1;
          if (init_cnt_r == IW'(INIT_N - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_xfer) begin
            cmd_r  <= pba_cmd_t'(in_tuser);
            sid_r  <= SAW'(in_tdata[7:0]);
            inr_r  <= (32'(in_tdata[7:0]) < MAX_SEQS);
            tc_r   <= in_tdata[23:8];
            ctx_r  <= in_tdata[39:24];
            idx_r  <= in_tdata[45:40];
            base_r <= LAW'(32'(SAW'(in_tdata[7:0])) * MAX_BLOCKS_PER_SEQ);
            div_req_r.dividend <= DIVD_W'(in_tdata[23:8]) + DIVD_W'(bs_eff) - 1'b1;
            div_req_r.divisor  <= bs_eff;
            state_r <= S_DIVA;
          end
        end
        S_DIVA: begin
          if (div_rsp.done) begin
            have_r   <= inr_r && seq_rdata_r[LW];
            len_r    <= seq_rdata_r[LW-1:0];
            need_a_r <= div_rsp.quot;
            div_req_r.dividend <= DIVD_W'(ctx_r);
            div_req_r.divisor  <= bs_eff;
            state_r <= S_DIVB;
          end
        end
        S_DIVB: begin
          if (div_rsp.done) begin
            if (grow_now) begin
              grow_r <= 1'b1;
              div_req_r.dividend <= DIVD_W'(tc_r) - DIVD_W'(slack) - 1'b1;
              div_req_r.divisor  <= bs_eff;
              state_r <= S_DIVC;
            end else begin
              grow_r  <= 1'b0;
              state_r <= S_DECIDE;
            end
          end
        end
        S_DIVC: begin
          if (div_rsp.done) begin
            need_c_r <= div_rsp.quot + 1'b1;
            state_r  <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          status_r <= dec_status;
          if (dec_new) begin
            len_r  <= '0;
            have_r <= 1'b1;
          end
          mv_cnt_r <= dec_cnt;
          pos_r    <= '0;
          unique case (dec_act)
            ACT_POP:  state_r <= S_POP_RD;
            ACT_PUSH: state_r <= S_PUSH_RD;
            default:  state_r <= S_FINISH;
          endcase
        end
        S_POP_RD: state_r <= S_POP_WR;
        S_POP_WR: begin
          len_r        <= len_r + 1'b1;
          free_total_r <= free_total_r - 1'b1;
          free_head_r  <= (32'(free_head_r) == POOL_BLOCKS - 1) ? '0 : free_head_r + 1'b1;
          mv_cnt_r     <= mv_cnt_r - 1'b1;
          state_r      <= (mv_cnt_r == LW'(1)) ? S_FINISH : S_POP_RD;
        end
        S_PUSH_RD: state_r <= S_PUSH_WR;
        S_PUSH_WR: begin
          free_total_r <= free_total_r + 1'b1;
          pos_r        <= pos_r + 1'b1;
          if (pos_r == len_r - 1'b1) begin
            len_r   <= '0;
            have_r  <= 1'b0;
            state_r <= S_FINISH;
          end else begin
            state_r <= S_PUSH_RD;
          end
        end
        S_FINISH: state_r <= S_RESULT;
        S_RESULT: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {5'd0, have_r, (free_total_r != '0), can_alloc,
                            OFREE_W'(free_total_r),
                            have_r ? OLEN_W'(len_r) : OLEN_W'(0),
                            bid, status_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Free queue memory: init fill and returned blocks.
  always_ff @(posedge clk) begin
    if (state_r == S_INIT && 32'(init_cnt_r) < POOL_BLOCKS) begin
      fq_mem[QAW'(init_cnt_r)] <= QAW'(init_cnt_r);
    end else if (state_r == S_PUSH_WR) begin
      fq_mem[fq_tail] <= list_rdata_r;
    end
    fq_rdata_r <= fq_mem[free_head_r];
  end

  // Block list memory.
  always_ff @(posedge clk) begin
    if (state_r == S_POP_WR) begin
      list_mem[list_waddr] <= fq_rdata_r;
    end
    list_rdata_r <= list_mem[list_raddr];
  end

  // Sequence table memory: valid flag and list length.
  always_ff @(posedge clk) begin
    if (state_r == S_INIT && 32'(init_cnt_r) < MAX_SEQS) begin
      seq_mem[SAW'(init_cnt_r)] <= '0;
    end else if (state_r == S_FINISH && inr_r) begin
      seq_mem[sid_r] <= {have_r, len_r};
    end
    seq_rdata_r <= seq_mem[seq_raddr];
  end

`ifndef SYNTHESIS
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(free_total_r) <= POOL_BLOCKS)
    else $error("free count exceeds pool size");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP_WR) |-> (free_total_r != '0))
    else $error("block taken from an empty free queue");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH_WR) |=> (free_total_r == $past(free_total_r) + 1'b1))
    else $error("returned block not counted");

  a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP_WR) |-> (32'(len_r) < MAX_BLOCKS_PER_SEQ))
    else $error("block list overflow");
`endif

endmodule
`default_nettype wire

// ===== tb/paged_block_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_block_allocator_tb
// Drives commands and register writes into the block allocator, predicts each
// result from a private model of the free queue and the block lists, and
// checks every result field by field. Both stream sides idle at random.
// ----------------------------------------------------------------------------
import pba_pkg::*;

// Keeps the expected pool state and the queue of expected results.
class pba_scoreboard;
  int unsigned blk_size;
  int unsigned reserve;
  bit [9:0]    free_ids[1024];
  int unsigned free_head;
  int unsigned free_total;
  bit [9:0]    lists[256][64];
  int unsigned lens[256];
  bit          owned[256];
  bit [34:0]   expected_results[$];
  int          errors;

  function new();
    blk_size = 32'(BS_RESET);
    reserve = 32'(RES_RESET);
    for (int i = 0; i < 1024; i++) free_ids[i] = i[9:0];
    free_head = 0;
    free_total = 1024;
    for (int s = 0; s < 256; s++) begin
      lens[s] = 0;
      owned[s] = 1'b0;
    end
    errors = 0;
  endfunction

  function void write_reg(logic idx, logic [12:0] data);
    if (idx == REG_BLOCK_SIZE) blk_size = 32'(data);
    else reserve = 32'(data[10:0]);
  endfunction

  // A block size of zero behaves as one.
  function int unsigned eff_size();
    return (blk_size == 0) ? 1 : blk_size;
  endfunction

  function int unsigned blocks_for(int unsigned tokens);
    return (tokens + eff_size() - 1) / eff_size();
  endfunction

  // Moves n ids from the head of the free queue onto the end of a list.
  function void grow_list(int unsigned s, int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      lists[s][lens[s]] = free_ids[free_head];
      free_head = (free_head + 1) % 1024;
      free_total--;
      lens[s]++;
    end
  endfunction

  // Applies one accepted command and queues the result it should produce.
  function void note_command(logic [2:0] cmd, logic [47:0] d);
    int unsigned s, tc, ctx, idx, need, slack, len;
    pba_status_t st;
    logic signed [10:0] bid;
    bit can_alloc;
    s = 32'(d[7:0]);
    tc = 32'(d[23:8]);
    ctx = 32'(d[39:24]);
    idx = 32'(d[45:40]);
    st = ST_OK;
    case (cmd)
      CMD_ALLOC: begin
        need = blocks_for(tc);
        if (tc == 0) st = ST_BADCNT;
        else if (owned[s]) st = ST_EXISTS;
        else if (need > 64) st = ST_FULL;
        else if (free_total < need + reserve) st = ST_NOFREE;
        else begin
          lens[s] = 0;
          grow_list(s, need);
          owned[s] = 1'b1;
        end
      end
      CMD_FREE: begin
        if (!owned[s]) st = ST_UNKNOWN;
        else begin
          // Blocks return to the queue tail in list order.
          for (int unsigned i = 0; i < lens[s]; i++) begin
            free_ids[(free_head + free_total) % 1024] = lists[s][i];
            free_total++;
          end
          lens[s] = 0;
          owned[s] = 1'b0;
        end
      end
      CMD_APPB: begin
        if (free_total == 0) st = ST_NOFREE;
        else if (!owned[s]) st = ST_UNKNOWN;
        else if (lens[s] >= 64) st = ST_FULL;
        else grow_list(s, 1);
      end
      CMD_APPT: begin
        if (tc == 0) st = ST_BADCNT;
        else if (!owned[s]) st = ST_UNKNOWN;
        else begin
          slack = (eff_size() - ctx % eff_size()) % eff_size();
          if (tc > slack) begin
            need = (tc - slack - 1) / eff_size() + 1;
            if (free_total <= need) st = ST_NOFREE;
            else if (lens[s] + need > 64) st = ST_FULL;
            else grow_list(s, need);
          end
        end
      end
      CMD_READ: begin
        if (!owned[s]) st = ST_UNKNOWN;
      end
      default: ;
    endcase
    len = owned[s] ? lens[s] : 0;
    bid = BLOCK_NONE;
    if (owned[s] && idx < len) bid = {1'b0, lists[s][idx]};
    can_alloc = (tc != 0) && (free_total >= blocks_for(tc) + reserve);
    expected_results.push_back({owned[s], free_total != 0, can_alloc,
                                free_total[10:0], len[6:0], bid, st});
  endfunction

  task report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Compares one accepted result with the oldest expectation.
  task check_result(logic [39:0] d);
    bit [34:0] e;
    if (expected_results.size() == 0) begin
      $display("unexpected result transfer at %0t", $realtime);
      errors++;
      return;
    end
    e = expected_results.pop_front();
    if (d[2:0] !== e[2:0]) report("status", int'(d[2:0]), int'(e[2:0]));
    if (d[13:3] !== e[13:3])
      report("block_id", int'($signed(d[13:3])), int'($signed(e[13:3])));
    if (d[20:14] !== e[20:14]) report("list_length", int'(d[20:14]), int'(e[20:14]));
    if (d[31:21] !== e[31:21]) report("free_count", int'(d[31:21]), int'(e[31:21]));
    if (d[32] !== e[32]) report("alloc_ok", int'(d[32]), int'(e[32]));
    if (d[33] !== e[33]) report("append_ok", int'(d[33]), int'(e[33]));
    if (d[34] !== e[34]) report("has_seq", int'(d[34]), int'(e[34]));
  endtask
endclass

module paged_block_allocator_tb;
  localparam int STALL_LIMIT = 8000;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [12:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  pba_scoreboard pool_model;
  bit            calm;       // no idling on either side
  bit            long_hold;  // receiver holds off for a long stretch
  int            quiet_cycles;

  paged_block_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Monitor: checks results first, since they belong to earlier commands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) pool_model.check_result(out_tdata);
      if (in_tvalid && in_tready) pool_model.note_command(in_tuser, in_tdata);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("paged_block_allocator_tb NOT OK");
      $finish;
    end
  end

  // Result receiver with random stall bursts and one long hold-off.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_tready = 1'b0;
        repeat (400) @(negedge clk);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  task send_cmd(logic [2:0] cmd, logic [7:0] seq, logic [15:0] tokens,
                logic [15:0] ctx, logic [5:0] idx);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = cmd;
    in_tdata = {2'b00, idx, ctx, tokens, seq};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Drops the command valid and waits until every expected result is in.
  task drain();
    in_tvalid = 1'b0;
    while (pool_model.expected_results.size() != 0) @(negedge clk);
  endtask

  task write_reg(logic idx, logic [12:0] data);
    drain();
    // Let the sequencer settle before touching a register.
    repeat (250) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    pool_model.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One random command, mostly well-formed and aimed at a few hot sequences.
  task send_random();
    int unsigned pick, span;
    logic [7:0] seq;
    logic [15:0] tokens;
    pick = $urandom_range(0, 99);
    seq = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 23)) : 8'($urandom_range(0, 255));
    span = pool_model.eff_size() * 64;
    if (span > 65535) span = 65535;
    tokens = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 65535)) :
                                            16'($urandom_range(1, span));
    if (pick < 25)
      send_cmd(CMD_ALLOC, seq, tokens, 16'($urandom), 6'($urandom));
    else if (pick < 45)
      send_cmd(CMD_FREE, seq, 16'($urandom), 16'($urandom), 6'($urandom));
    else if (pick < 55)
      send_cmd(CMD_APPB, seq, 16'($urandom), 16'($urandom), 6'($urandom));
    else if (pick < 75)
      send_cmd(CMD_APPT, seq, 16'($urandom_range(0, 3 * pool_model.eff_size())),
               16'($urandom), 6'($urandom));
    else if (pick < 95)
      send_cmd(CMD_READ, seq, tokens, 16'($urandom), 6'($urandom_range(0, 63)));
    else
      send_cmd(3'($urandom_range(0, 7)), 8'($urandom), 16'($urandom), 16'($urandom),
               6'($urandom));
  endtask

  initial begin
    pool_model = new();
    calm = 1'b0;
    long_hold = 1'b0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_BLOCK_SIZE;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_READ;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed: error codes, list limits, slack handling and unused commands.
    send_cmd(CMD_ALLOC, 8'd0, 16'd0, 16'd0, 6'd0);
    send_cmd(CMD_ALLOC, 8'd255, 16'hFFFF, 16'hFFFF, 6'd63);
    send_cmd(CMD_ALLOC, 8'd0, 16'd1024, 16'd0, 6'd63);
    send_cmd(CMD_ALLOC, 8'd0, 16'd5, 16'd0, 6'd0);
    send_cmd(CMD_APPB, 8'd0, 16'd0, 16'd0, 6'd0);
    send_cmd(CMD_APPT, 8'd0, 16'd1, 16'd1024, 6'd1);
    send_cmd(CMD_APPT, 8'd0, 16'd0, 16'd0, 6'd0);
    send_cmd(CMD_APPT, 8'd5, 16'd3, 16'd0, 6'd0);
    send_cmd(CMD_FREE, 8'd5, 16'd0, 16'd0, 6'd0);
    send_cmd(CMD_READ, 8'd5, 16'd0, 16'd0, 6'd0);
    send_cmd(CMD_APPB, 8'd5, 16'd0, 16'd0, 6'd0);
    send_cmd(3'd5, 8'hFF, 16'hFFFF, 16'hFFFF, 6'h3F);
    send_cmd(3'd6, 8'd0, 16'd0, 16'd0, 6'd0);
    send_cmd(3'd7, 8'd0, 16'd1, 16'd1, 6'd1);
    send_cmd(CMD_ALLOC, 8'd1, 16'd17, 16'd0, 6'd1);
    send_cmd(CMD_APPT, 8'd1, 16'd15, 16'd17, 6'd2);
    send_cmd(CMD_APPT, 8'd1, 16'd16, 16'd17, 6'd2);
    send_cmd(CMD_APPT, 8'd1, 16'hFFFF, 16'hFFFF, 6'd2);
    send_cmd(CMD_APPB, 8'd1, 16'd0, 16'd0, 6'd3);
    send_cmd(CMD_FREE, 8'd1, 16'd0, 16'd0, 6'd0);
    send_cmd(CMD_FREE, 8'd0, 16'd0, 16'd0, 6'd0);

    // Directed: empty the pool with one-token blocks, then hit no-free paths.
    write_reg(REG_BLOCK_SIZE, 13'd1);
    for (int s = 10; s < 26; s++) send_cmd(CMD_ALLOC, 8'(s), 16'd64, 16'd0, 6'd0);
    send_cmd(CMD_APPB, 8'd10, 16'd0, 16'd0, 6'd0);
    send_cmd(CMD_APPT, 8'd10, 16'd1, 16'd64, 6'd0);
    send_cmd(CMD_ALLOC, 8'd30, 16'd1, 16'd0, 6'd0);
    for (int s = 10; s < 26; s++) send_cmd(CMD_FREE, 8'(s), 16'd0, 16'd0, 6'd0);

    // Random phases under different register settings.
    long_hold = 1'b1;
    repeat (140) send_random();
    write_reg(REG_BLOCK_SIZE, 13'd4096);
    write_reg(REG_RESERVED, 13'd1024);
    repeat (70) send_random();
    drain();
    repeat (80) send_random();
    write_reg(REG_BLOCK_SIZE, 13'd0);
    write_reg(REG_RESERVED, 13'h7FF);
    repeat (130) send_random();
    write_reg(REG_BLOCK_SIZE, 13'h1FFF);
    write_reg(REG_RESERVED, 13'd5);
    repeat (130) send_random();
    write_reg(REG_BLOCK_SIZE, 13'd3);
    write_reg(REG_RESERVED, 13'd100);
    repeat (130) send_random();
    write_reg(REG_BLOCK_SIZE, 13'd16);
    write_reg(REG_RESERVED, 13'd0);
    repeat (120) send_random();
    calm = 1'b1;
    repeat (120) send_random();

    drain();
    repeat (300) @(negedge clk);
    if (pool_model.errors == 0 && pool_model.expected_results.size() == 0) begin
      $display("paged_block_allocator_tb OK");
    end else begin
      $display("paged_block_allocator_tb NOT OK");
    end
    $finish;
  end
endmodule
